### hdl/pid_pkg.sv
// Shared types, register codes and the microcode table of the PID step block.
// No dependencies; imported by pid_controller_step_top.
`timescale 1ns / 1ps
`default_nettype none

package pid_pkg;

  localparam int DataW = 32;
  localparam int StepW = 31;
  localparam int ProdW = 64;
  localparam int AccW  = 65;
  localparam int SatW  = 66;
  localparam int QFrac = 16;
  localparam int DivW  = 49;  // |error change| << 16 needs 49 bits
  localparam int DivCntW = 6;

  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_SET_POINT = 3'd0;
  localparam cfg_index_t REG_GAIN_P    = 3'd1;
  localparam cfg_index_t REG_GAIN_I    = 3'd2;
  localparam cfg_index_t REG_GAIN_D    = 3'd3;
  localparam cfg_index_t REG_TIME_STEP = 3'd4;

  typedef logic [3:0] step_t;
  localparam step_t ST_WAIT     = 4'd0;
  localparam step_t ST_ERR      = 4'd1;
  localparam step_t ST_DIV_GO   = 4'd2;
  localparam step_t ST_INTEG    = 4'd3;
  localparam step_t ST_ACC_P    = 4'd4;
  localparam step_t ST_ACC_I    = 4'd5;
  localparam step_t ST_DIV_WAIT = 4'd6;
  localparam step_t ST_DERIV    = 4'd7;
  localparam step_t ST_MUL_D    = 4'd8;
  localparam step_t ST_ACC_D    = 4'd9;
  localparam step_t ST_OUT      = 4'd10;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_INPUT,
    HOLD_DIV_BUSY,
    HOLD_OUT_FULL
  } hold_t;

  typedef enum logic [1:0] {
    MUL_ERR_DT,
    MUL_KP_ERR,
    MUL_KI_INT,
    MUL_KD_DER
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_KEEP,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    hold_t    hold;
    step_t    next;
    logic     in_take;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     err_we;
    logic     div_start;
    logic     int_we;
    logic     der_we;
    logic     out_we;
  } ucode_t;

  localparam ucode_t UC_NOP = '{
    hold: HOLD_NONE, next: ST_WAIT, in_take: 1'b0, mul_en: 1'b0, mul_sel: MUL_ERR_DT,
    acc_op: ACC_KEEP, err_we: 1'b0, div_start: 1'b0, int_we: 1'b0, der_we: 1'b0,
    out_we: 1'b0
  };

  // One control word per step. A word whose hold condition is true does nothing
  // and repeats; otherwise its actions fire and control moves to next.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = UC_NOP;
    case (step)
      ST_WAIT: begin
        uc.hold = HOLD_NO_INPUT; uc.in_take = 1'b1; uc.next = ST_ERR;
      end
      ST_ERR: begin
        uc.err_we = 1'b1; uc.next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        uc.div_start = 1'b1; uc.mul_en = 1'b1; uc.mul_sel = MUL_ERR_DT;
        uc.next = ST_INTEG;
      end
      ST_INTEG: begin
        uc.int_we = 1'b1; uc.mul_en = 1'b1; uc.mul_sel = MUL_KP_ERR;
        uc.next = ST_ACC_P;
      end
      ST_ACC_P: begin
        uc.acc_op = ACC_LOAD; uc.mul_en = 1'b1; uc.mul_sel = MUL_KI_INT;
        uc.next = ST_ACC_I;
      end
      ST_ACC_I: begin
        uc.acc_op = ACC_ADD; uc.next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        uc.hold = HOLD_DIV_BUSY; uc.next = ST_DERIV;
      end
      ST_DERIV: begin
        uc.der_we = 1'b1; uc.next = ST_MUL_D;
      end
      ST_MUL_D: begin
        uc.mul_en = 1'b1; uc.mul_sel = MUL_KD_DER; uc.next = ST_ACC_D;
      end
      ST_ACC_D: begin
        uc.acc_op = ACC_ADD; uc.next = ST_OUT;
      end
      ST_OUT: begin
        uc.hold = HOLD_OUT_FULL; uc.out_we = 1'b1; uc.next = ST_WAIT;
      end
      default: begin
        uc = UC_NOP;
      end
    endcase
    return uc;
  endfunction

  // Saturates a two's complement value to 32 bits signed.
  function automatic logic [DataW-1:0] sat32(input logic [SatW-1:0] v);
    logic [DataW-1:0] r;
    if (!v[SatW-1] && (|v[SatW-2:DataW-1])) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (v[SatW-1] && !(&v[SatW-2:DataW-1])) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/pid_controller_step_top.sv
// Discrete PID controller step in signed Q16.16, driven by a microcode table.
// An input beat is taken only in the wait step, so no new measurement is accepted until
// the last result is in the output register. The derivative comes from a one-bit-per-cycle
// restoring divider (49 steps), and the steps around it use the shared multiplier.
// Reset (synchronous, active low) loads register defaults and clears the integral,
// the last error and the sequencer; no clearing pass is needed.
// Depends on pid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_step_top
  import pid_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [DataW-1:0] in_process_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [DataW-1:0] out_control_value,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [DataW-1:0] cfg_data
);

  logic [DataW-1:0] set_point_r, gain_p_r, gain_i_r, gain_d_r;
  logic [StepW-1:0] time_step_r;
  logic [DataW-1:0] last_error_r, last_error_nxt;
  logic [DataW-1:0] integral_r, integral_nxt;

  step_t  pc_r, pc_nxt;
  ucode_t uc;
  logic   hold, fire;

  logic [DataW-1:0] pv_r, err_r, err_nxt, deriv_r, deriv_nxt;
  logic [ProdW-1:0] prod_r;
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [DataW-1:0] out_data_r;
  logic             out_full_r, out_full_nxt;

  logic signed [DataW:0]     mul_a, mul_b;
  logic signed [2*DataW+1:0] mul_full;
  logic [StepW-1:0]          dt;

  logic [DataW:0]   err_diff, d_diff, d_mag;
  logic [DivW-1:0]  div_q_r;
  logic [StepW-1:0] div_rem_r;
  logic [DivCntW-1:0] div_cnt_r;
  logic             div_neg_r, div_busy;
  logic [DataW-1:0] div_trial, div_sub;
  logic             div_bit;

  assign cfg_ready = 1'b1;
  assign dt = (time_step_r == '0) ? {{(StepW-1){1'b0}}, 1'b1} : time_step_r;

  // Sequencer
  assign uc = ucode_rom(pc_r);

  always_comb begin
    case (uc.hold)
      HOLD_NO_INPUT: hold = !in_valid;
      HOLD_DIV_BUSY: hold = div_busy;
      HOLD_OUT_FULL: hold = out_full_r;
      default:       hold = 1'b0;
    endcase
  end

  assign fire     = !hold;
  assign pc_nxt   = fire ? uc.next : pc_r;
  assign in_stall = !uc.in_take;

  // Datapath
  assign err_diff = {set_point_r[DataW-1], set_point_r} - {pv_r[DataW-1], pv_r};
  assign err_nxt  = sat32({{(SatW-DataW-1){err_diff[DataW]}}, err_diff});

  assign integral_nxt = sat32({{(SatW-DataW){integral_r[DataW-1]}}, integral_r}
                              + {{(SatW-ProdW+QFrac){prod_r[ProdW-1]}},
                                 prod_r[ProdW-1:QFrac]});
  assign last_error_nxt = err_r;

  always_comb begin
    case (uc.mul_sel)
      MUL_ERR_DT: begin
        mul_a = {err_r[DataW-1], err_r};
        mul_b = {2'b00, dt};
      end
      MUL_KP_ERR: begin
        mul_a = {gain_p_r[DataW-1], gain_p_r};
        mul_b = {err_r[DataW-1], err_r};
      end
      MUL_KI_INT: begin
        mul_a = {gain_i_r[DataW-1], gain_i_r};
        mul_b = {integral_r[DataW-1], integral_r};
      end
      default: begin
        mul_a = {gain_d_r[DataW-1], gain_d_r};
        mul_b = {deriv_r[DataW-1], deriv_r};
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_comb begin
    case (uc.acc_op)
      ACC_LOAD: acc_nxt = {prod_r[ProdW-1], prod_r};
      ACC_ADD:  acc_nxt = acc_r + {prod_r[ProdW-1], prod_r};
      default:  acc_nxt = acc_r;
    endcase
  end

  // Divider: magnitude of (error - last_error) << 16 over the time step.
  assign d_diff = {err_r[DataW-1], err_r} - {last_error_r[DataW-1], last_error_r};
  assign d_mag  = d_diff[DataW] ? (~d_diff + 1'b1) : d_diff;

  assign div_busy  = (div_cnt_r != '0);
  assign div_trial = {div_rem_r, div_q_r[DivW-1]};
  assign div_sub   = div_trial - {1'b0, dt};
  assign div_bit   = (div_trial >= {1'b0, dt});

  always_comb begin
    if (!div_neg_r) begin
      deriv_nxt = (|div_q_r[DivW-1:DataW-1]) ? {1'b0, {(DataW-1){1'b1}}}
                                              : {1'b0, div_q_r[DataW-2:0]};
    end else begin
      // The most negative quotient that still fits is exactly 2^31.
      if ((|div_q_r[DivW-1:DataW]) ||
          (div_q_r[DataW-1] && (|div_q_r[DataW-2:0]))) begin
        deriv_nxt = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        deriv_nxt = ~div_q_r[DataW-1:0] + 1'b1;
      end
    end
  end

  always_comb begin
    out_full_nxt = out_full_r;
    if (fire && uc.out_we) begin
      out_full_nxt = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_full_nxt = 1'b0;
    end
  end

  assign out_valid         = out_full_r;
  assign out_control_value = out_data_r;

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_WAIT;
      out_full_r   <= 1'b0;
      div_cnt_r    <= '0;
      last_error_r <= '0;
      integral_r   <= '0;
      set_point_r  <= 32'd32768;
      gain_p_r     <= 32'd32768;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      time_step_r  <= 31'd65536;
    end else begin
      pc_r       <= pc_nxt;
      out_full_r <= out_full_nxt;
      if (fire && uc.div_start) begin
        div_cnt_r <= DivCntW'(DivW);
      end else if (div_busy) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      if (fire && uc.int_we) begin
        integral_r   <= integral_nxt;
        last_error_r <= last_error_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SET_POINT: set_point_r <= cfg_data;
          REG_GAIN_P:    gain_p_r    <= cfg_data;
          REG_GAIN_I:    gain_i_r    <= cfg_data;
          REG_GAIN_D:    gain_d_r    <= cfg_data;
          REG_TIME_STEP: time_step_r <= cfg_data[StepW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pv_r <= in_process_value;
    end
    if (fire && uc.err_we) begin
      err_r <= err_nxt;
    end
    if (fire && uc.mul_en) begin
      prod_r <= mul_full[ProdW-1:0];
    end
    if (fire) begin
      acc_r <= acc_nxt;
    end
    if (fire && uc.der_we) begin
      deriv_r <= deriv_nxt;
    end
    if (fire && uc.out_we) begin
      out_data_r <= sat32({{(SatW-AccW+QFrac){acc_r[AccW-1]}}, acc_r[AccW-1:QFrac]});
    end
    if (fire && uc.div_start) begin
      div_q_r   <= {d_mag, {QFrac{1'b0}}};
      div_rem_r <= '0;
      div_neg_r <= d_diff[DataW];
    end else if (div_busy) begin
      div_q_r   <= {div_q_r[DivW-2:0], div_bit};
      div_rem_r <= div_bit ? div_sub[StepW-1:0] : div_trial[StepW-1:0];
    end
  end

endmodule

`default_nettype wire

### test/pid_controller_step_top_tb.sv
// Self-checking bench for pid_controller_step_top: a queue-fed driver, a clocked
// monitor and a Q16.16 PID predictor that tracks every register write.
// Depends on pid_pkg and pid_controller_step_top.
`timescale 1ns / 1ps

module pid_controller_step_top_tb;
  import pid_pkg::*;

  localparam int     WatchdogLimit = 2000;
  localparam int     HoldOffCycles = 300;
  localparam int     ItemTarget    = 950;
  localparam longint S32Max        = 64'sd2147483647;
  localparam longint S32Min        = -64'sd2147483648;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [DataW-1:0] in_process_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [DataW-1:0] out_control_value;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_index_t       cfg_index = REG_SET_POINT;
  logic [DataW-1:0] cfg_data = '0;

  // Controller settings and state as the block should hold them.
  logic signed [DataW-1:0] set_pt = 32'sd32768;
  logic signed [DataW-1:0] k_p    = 32'sd32768;
  logic signed [DataW-1:0] k_i    = '0;
  logic signed [DataW-1:0] k_d    = '0;
  logic        [StepW-1:0] dt_reg = 31'd65536;
  longint                  last_err = 0;
  longint                  integ    = 0;

  logic [DataW-1:0] pv_pending[$];
  logic [DataW-1:0] ctl_expected[$];
  logic [DataW-1:0] ctl_want;

  int n_pushed = 0, n_accepted = 0, n_checked = 0, n_errors = 0;
  int n_cfg = 0, n_settings = 0;
  int tx_wait = 0, rx_wait = 0, rx_hold_left = 0;
  int hold_asked = 0, hold_served = 0;
  int quiet_cycles = 0;
  bit tx_idle_on = 1'b1, rx_idle_on = 1'b1;

  always #6 clk = ~clk;

  pid_controller_step_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_process_value (in_process_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_control_value(out_control_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  function automatic longint clamp32(input longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  // One control update: advances the kept error and integral, returns the output.
  function automatic logic [DataW-1:0] pid_update(input logic signed [DataW-1:0] pv);
    longint           err, dt, deriv, p_term, i_term, d_term;
    logic signed [95:0] total;
    dt = (dt_reg == '0) ? 64'sd1 : longint'(dt_reg);
    err = clamp32(longint'(set_pt) - longint'(pv));
    deriv = clamp32(((err - last_err) * 64'sd65536) / dt);
    integ = clamp32(integ + ((err * dt) >>> QFrac));
    last_err = err;
    p_term = longint'(k_p) * err;
    i_term = longint'(k_i) * integ;
    d_term = longint'(k_d) * deriv;
    total = p_term + i_term + d_term;
    total = total >>> QFrac;
    if (total > S32Max) return 32'h7fff_ffff;
    if (total < S32Min) return 32'h8000_0000;
    return total[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] rand_word();
    int s;
    case ($urandom_range(0, 4))
      0: begin
        s = $urandom_range(0, 262143);
        return s - 131072;
      end
      1: begin
        s = $urandom_range(0, 33554431);
        return s - 16777216;
      end
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          4: return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_gain();
    int s;
    if ($urandom_range(0, 2) != 0) begin
      s = $urandom_range(0, 262143);
      return s - 131072;
    end
    return rand_word();
  endfunction

  function automatic logic [DataW-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return $urandom_range(1, 1048576);
      2: return $urandom_range(1, 256);
      3: return $urandom();
      4: return ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'h7fff_ffff;
      default: return $urandom_range(4096, 262144);
    endcase
  endfunction

  // Mostly measurements near the set point, as a settling loop would see them.
  function automatic logic [DataW-1:0] pick_pv();
    int s;
    if ($urandom_range(0, 9) < 6) begin
      s = $urandom_range(0, 262143);
      return set_pt + (s - 131072);
    end
    return rand_word();
  endfunction

  // Driver: a new beat is offered only when the previous one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        ctl_expected.push_back(pid_update(in_process_value));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pv_pending.size() != 0) begin
          in_valid <= 1'b1;
          in_process_value <= pv_pending.pop_front();
          tx_wait = tx_idle_on ? $urandom_range(0, 15) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and paces out_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ctl_expected.size() == 0) begin
          n_errors++;
          $display("%0t: control_value expected none, actual %h", $time, out_control_value);
        end else begin
          ctl_want = ctl_expected.pop_front();
          n_checked++;
          if (out_control_value !== ctl_want) begin
            n_errors++;
            $display("%0t: control_value expected %h, actual %h", $time, ctl_want,
                     out_control_value);
          end
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      if (hold_asked != hold_served) begin
        hold_served++;
        rx_hold_left = HoldOffCycles;
      end else if (rx_hold_left != 0) begin
        rx_hold_left--;
      end
      out_stall <= (rx_wait != 0) || (rx_hold_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("pid_controller_step_top_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic push_pv(input logic [DataW-1:0] v);
    pv_pending.push_back(v);
    n_pushed++;
  endtask

  // Returns once every sent item has its result back.
  task automatic wait_drained();
    @(posedge clk);
    while (n_accepted != n_pushed || ctl_expected.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input cfg_index_t idx, input logic [DataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SET_POINT: set_pt = val;
      REG_GAIN_P:    k_p = val;
      REG_GAIN_I:    k_i = val;
      REG_GAIN_D:    k_d = val;
      REG_TIME_STEP: dt_reg = val[StepW-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic write_all(input logic [DataW-1:0] sp, input logic [DataW-1:0] kp,
                           input logic [DataW-1:0] ki, input logic [DataW-1:0] kd,
                           input logic [DataW-1:0] dt, input int junk);
    write_reg(REG_SET_POINT, sp);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_TIME_STEP, dt);
    // Indexes past the last register must leave every setting alone.
    for (int j = 0; j < junk; j++) begin
      write_reg(cfg_index_t'(REG_TIME_STEP + 1 + j), $urandom());
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin : stim
    int phase;
    int n_items;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings out of reset, then full-scale, zero and small measurements.
    push_pv(32'h0000_0000);
    push_pv(32'h7fff_ffff);
    push_pv(32'h8000_0000);
    push_pv(32'h0000_8000);
    push_pv(32'hffff_0000);
    wait_drained();

    // Largest gains with a zero time step: error and derivative both saturate.
    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 0);
    push_pv(32'h8000_0000);
    push_pv(32'h7fff_ffff);
    push_pv(32'h8000_0000);
    push_pv(32'h0000_0000);
    wait_drained();

    // Longest step with bit 31 set on the write: the integral saturates at once.
    write_all(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 3);
    push_pv(32'h7fff_ffff);
    push_pv(32'h7fff_ffff);
    push_pv(32'h8000_0000);
    push_pv(32'h0000_0000);

    phase = 0;
    while (n_pushed < ItemTarget) begin
      wait_drained();
      write_all(rand_word(), pick_gain(), pick_gain(), pick_gain(), pick_step(),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 1) begin
        tx_idle_on = 1'b0;
      end
      n_items = $urandom_range(20, 60);
      for (int k = 0; k < n_items; k++) begin
        // Now and then the sender stops until the block has answered everything.
        if (k == n_items / 2 && phase % 3 == 2) begin
          wait_drained();
        end
        push_pv(pick_pv());
      end
      if (phase == 1) begin
        hold_asked++;
      end
      phase++;
    end

    wait_drained();
    repeat (80) @(posedge clk);
    $display("%0d measurements sent, %0d control values checked, %0d register writes",
             n_pushed, n_checked, n_cfg);
    $display("across %0d controller settings including saturating and zero-step cases",
             n_settings);
    if (n_errors == 0) begin
      $display("pid_controller_step_top_tb: done, clean");
    end else begin
      $display("pid_controller_step_top_tb: done, errors");
    end
    $finish;
  end

endmodule
